@@ hw/rtl/assert_macros.svh @@
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define FSL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds during reset
`define FSL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/fsl_pkg.sv @@
`timescale 1ns / 1ps

package fsl_pkg;

   // default counter width for the delay counter
   localparam int COUNTER_WIDTH_DEF = 16;

   // field widths
   localparam int OP_W    = 2;
   localparam int BYTE_W  = 8;
   localparam int PHASE_W = 3;
   localparam int TICK_W  = 16;
   localparam int DUMMY_W = 3;
   localparam int BEAT_W  = 6;
   localparam int IDX_W   = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_START  = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
   localparam logic [OP_W-1:0] OP_BYTE   = 2'd2;
   localparam int OP_FINISH_CODE = 3;
   localparam logic [OP_W-1:0] OP_FINISH = OP_W'(OP_FINISH_CODE);

   // phase codes
   localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_HOLD  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_BOOT  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_READY = 3'd3;
   localparam logic [PHASE_W-1:0] PH_CONF  = 3'd4;
   localparam logic [PHASE_W-1:0] PH_FAIL  = 3'd5;

   // register indexes
   localparam logic [IDX_W-1:0] REG_RESET_HOLD = 2'd0;
   localparam logic [IDX_W-1:0] REG_BOOT_WAIT  = 2'd1;
   localparam logic [IDX_W-1:0] REG_DUMMY      = 2'd2;

   // register reset values
   localparam logic [TICK_W-1:0]  RESET_HOLD_DEF = 16'd16;
   localparam logic [TICK_W-1:0]  BOOT_WAIT_DEF  = 16'd24000;
   localparam logic [DUMMY_W-1:0] DUMMY_DEF      = 3'd7;

   // last beat index of one serial byte and the all-ones filler
   localparam logic [BEAT_W-1:0] BYTE_BEATS_M1 = 6'd7;
   localparam logic [BYTE_W-1:0] FILL_BYTE     = 8'hFF;

   // one decoded item waiting to be played out as results
   typedef struct packed {
      logic [BYTE_W-1:0]  shifter;
      logic [BEAT_W-1:0]  beats;
      logic               pulse;
      logic               reset_level;
      logic               select_level;
      logic [PHASE_W-1:0] phase_code;
      logic               rejected;
   } job_type;

endpackage

@@ hw/rtl/fsl_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fsl_ctrl #(
   parameter int COUNTER_WIDTH = fsl_pkg::COUNTER_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [fsl_pkg::IDX_W-1:0]     csr_index,
   input  logic [fsl_pkg::TICK_W-1:0]    csr_wdata,
   input  logic                          accept,
   input  logic [fsl_pkg::OP_W-1:0]      operation,
   input  logic [fsl_pkg::BYTE_W-1:0]    data_byte,
   input  logic                          done_pin,
   output fsl_pkg::job_type              job
);

   localparam int CMP_W = (COUNTER_WIDTH > fsl_pkg::TICK_W) ? COUNTER_WIDTH : fsl_pkg::TICK_W;

   logic [fsl_pkg::TICK_W-1:0]  hold_ff;
   logic [fsl_pkg::TICK_W-1:0]  boot_ff;
   logic [fsl_pkg::DUMMY_W-1:0] dummy_ff;

   logic [fsl_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [COUNTER_WIDTH-1:0]    delay_ff, delay_in;
   logic                        rst_ff, rst_in;
   logic                        sel_ff, sel_in;

   logic [COUNTER_WIDTH-1:0]    count_next;
   logic [fsl_pkg::TICK_W-1:0]  limit;
   logic                        tick_hit;
   logic                        rej;
   logic                        pulse;
   logic [fsl_pkg::BEAT_W-1:0]  beats;
   logic [fsl_pkg::BYTE_W-1:0]  shifter;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= fsl_pkg::RESET_HOLD_DEF;
         boot_ff  <= fsl_pkg::BOOT_WAIT_DEF;
         dummy_ff <= fsl_pkg::DUMMY_DEF;
      end else if (csr_we) begin
         case (csr_index)
            fsl_pkg::REG_RESET_HOLD: hold_ff  <= csr_wdata;
            fsl_pkg::REG_BOOT_WAIT:  boot_ff  <= csr_wdata;
            fsl_pkg::REG_DUMMY:      dummy_ff <= csr_wdata[fsl_pkg::DUMMY_W-1:0];
            default: ;
         endcase
      end
   end

   // delay counter compare, a zero limit ends the wait on the first tick
   assign count_next = delay_ff + 1'b1;
   assign limit      = (phase_ff == fsl_pkg::PH_HOLD) ? hold_ff : boot_ff;
   assign tick_hit   = (CMP_W'(count_next) >= CMP_W'(limit)) || (&count_next);

   // next phase and line levels for the offered item
   always_comb begin
      phase_in = phase_ff;
      delay_in = delay_ff;
      rst_in   = rst_ff;
      sel_in   = sel_ff;
      rej      = 1'b0;
      pulse    = 1'b0;
      beats    = '0;
      shifter  = data_byte;
      case (operation)
         fsl_pkg::OP_START: begin
            if (phase_ff == fsl_pkg::PH_IDLE || phase_ff == fsl_pkg::PH_CONF ||
                phase_ff == fsl_pkg::PH_FAIL) begin
               rst_in   = 1'b0;
               sel_in   = 1'b0;
               delay_in = '0;
               phase_in = fsl_pkg::PH_HOLD;
            end else begin
               rej = 1'b1;
            end
         end
         fsl_pkg::OP_TICK: begin
            if (phase_ff == fsl_pkg::PH_HOLD || phase_ff == fsl_pkg::PH_BOOT) begin
               if (tick_hit) begin
                  delay_in = '0;
                  if (phase_ff == fsl_pkg::PH_HOLD) begin
                     phase_in = fsl_pkg::PH_BOOT;
                     rst_in   = 1'b1;
                  end else begin
                     phase_in = fsl_pkg::PH_READY;
                  end
               end else begin
                  delay_in = count_next;
               end
            end
         end
         fsl_pkg::OP_BYTE: begin
            if (phase_ff == fsl_pkg::PH_READY) begin
               pulse = 1'b1;
               beats = fsl_pkg::BYTE_BEATS_M1;
            end else begin
               rej = 1'b1;
            end
         end
         fsl_pkg::OP_FINISH: begin
            if (phase_ff != fsl_pkg::PH_READY) begin
               rej = 1'b1;
            end else if (!done_pin) begin
               phase_in = fsl_pkg::PH_FAIL;
            end else begin
               phase_in = fsl_pkg::PH_CONF;
               if (dummy_ff != '0) begin
                  pulse   = 1'b1;
                  shifter = fsl_pkg::FILL_BYTE;
                  beats   = {dummy_ff, 3'b000} - 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // sequencing state, moves only when an item is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fsl_pkg::PH_IDLE;
         delay_ff <= '0;
         rst_ff   <= 1'b1;
         sel_ff   <= 1'b1;
      end else if (accept) begin
         phase_ff <= phase_in;
         delay_ff <= delay_in;
         rst_ff   <= rst_in;
         sel_ff   <= sel_in;
      end
   end

   // decoded job for the serializer
   always_comb begin
      job.shifter      = shifter;
      job.beats        = beats;
      job.pulse        = pulse;
      job.reset_level  = rst_in;
      job.select_level = sel_in;
      job.phase_code   = phase_in;
      job.rejected     = rej;
   end

   `FSL_ASSERT(a_rst_released, clock, reset, (phase_ff == fsl_pkg::PH_BOOT || phase_ff == fsl_pkg::PH_READY) |-> rst_ff, "reset line low after hold phase")
   `FSL_ASSERT(a_sel_active, clock, reset, (phase_ff != fsl_pkg::PH_IDLE) |-> !sel_ff, "select released after start")
   `FSL_ASSERT(a_delay_idle, clock, reset, (phase_ff != fsl_pkg::PH_HOLD && phase_ff != fsl_pkg::PH_BOOT) |-> (delay_ff == '0), "delay counter not cleared outside waits")

endmodule

@@ hw/rtl/fsl_serializer.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fsl_serializer (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  fsl_pkg::job_type job_in,
   output logic             job_free,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic             rsp_mosi,
   output logic             rsp_pulse,
   output logic             rsp_reset_level,
   output logic             rsp_select_level,
   output logic [fsl_pkg::PHASE_W-1:0] rsp_phase,
   output logic             rsp_rejected,
   output logic             rsp_last
);

   fsl_pkg::job_type job_ff;
   logic             job_valid_ff;
   logic             rsp_valid_ff;
   logic             beat_go;
   logic             job_done;

   // one beat leaves the job whenever the result register can take it
   assign beat_go  = job_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign job_done = beat_go && (job_ff.beats == '0);
   assign job_free = !job_valid_ff || job_done;

   // job register
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else if (accept) begin
         job_valid_ff <= 1'b1;
      end else if (job_done) begin
         job_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end else if (beat_go) begin
         job_ff.shifter <= {job_ff.shifter[fsl_pkg::BYTE_W-2:0],
                            job_ff.shifter[fsl_pkg::BYTE_W-1]};
         job_ff.beats   <= job_ff.beats - 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (beat_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_go) begin
         rsp_mosi         <= job_ff.pulse & job_ff.shifter[fsl_pkg::BYTE_W-1];
         rsp_pulse        <= job_ff.pulse;
         rsp_reset_level  <= job_ff.reset_level;
         rsp_select_level <= job_ff.select_level;
         rsp_phase        <= job_ff.phase_code;
         rsp_rejected     <= job_ff.rejected;
         rsp_last         <= (job_ff.beats == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `FSL_ASSERT(a_mosi_pulse, clock, reset, (rsp_valid_ff && rsp_mosi) |-> rsp_pulse, "mosi high without clock pulse")
   `FSL_ASSERT(a_rej_nopulse, clock, reset, (rsp_valid_ff && rsp_rejected) |-> (!rsp_pulse && rsp_last), "rejected item with pulses")
   `FSL_ASSERT(a_free_last, clock, reset, job_free |-> (!job_valid_ff || job_ff.beats == '0), "new item taken while beats remain")

endmodule

@@ hw/rtl/fpga_spi_config_loader_core.sv @@
`timescale 1ns / 1ps
// channel | direction | payload
// req     | in        | tuser: operation ; tdata: data_byte, done_pin
// rsp     | out       | tuser: clock_pulse, rejected ; tdata: mosi, reset/select, phase
// csr     | in        | write enable, register index, write data
//
// an item is decoded and takes effect in the cycle it is accepted
// results then leave at one per cycle while rsp_tready holds: one for most items, one per
// bit for a byte and per dummy byte on a good finish; the serializer beat counter sets this
// the next item is taken in the cycle the final result of the previous one
// moves into the result register, so a stalled rsp side stalls req only then
// reset is synchronous: phase idle, both lines high, registers at defaults
module fpga_spi_config_loader_core #(
   parameter int COUNTER_WIDTH = fsl_pkg::COUNTER_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [15:0]                req_tdata,  // [7:0] data_byte, [8] done_pin
   input  logic [fsl_pkg::OP_W-1:0]   req_tuser,  // [1:0] operation
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,  // [0] mosi, [1] reset_level,
                                                  // [2] select_level, [5:3] phase_code
   output logic [1:0]                 rsp_tuser,  // [0] clock_pulse, [1] rejected
   output logic                       rsp_tlast,
   input  logic                       csr_we,
   input  logic [fsl_pkg::IDX_W-1:0]  csr_index,
   input  logic [fsl_pkg::TICK_W-1:0] csr_wdata
);

   fsl_pkg::job_type            job;
   logic                        req_accept;
   logic                        job_free;
   logic                        mosi;
   logic                        pulse;
   logic                        reset_level;
   logic                        select_level;
   logic [fsl_pkg::PHASE_W-1:0] phase_code;
   logic                        rejected;

   assign req_tready = job_free;
   assign req_accept = req_tvalid && job_free;

   // phase sequencing and item decode
   fsl_ctrl #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (req_accept),
      .operation (req_tuser),
      .data_byte (req_tdata[7:0]),
      .done_pin  (req_tdata[8]),
      .job       (job)
   );

   // beat playout and result register
   fsl_serializer u_ser (
      .clock            (clock),
      .reset            (reset),
      .accept           (req_accept),
      .job_in           (job),
      .job_free         (job_free),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_mosi         (mosi),
      .rsp_pulse        (pulse),
      .rsp_reset_level  (reset_level),
      .rsp_select_level (select_level),
      .rsp_phase        (phase_code),
      .rsp_rejected     (rejected),
      .rsp_last         (rsp_tlast)
   );

   // result packing
   assign rsp_tdata = {2'b00, phase_code, select_level, reset_level, mosi};
   assign rsp_tuser = {rejected, pulse};

endmodule

@@ verif/config_loader_checker.sv @@
`timescale 1ns / 1ps

// watches the item channels and the register port, predicts every result
// and compares it with what the loader puts out
module config_loader_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [15:0]                req_tdata,  // [7:0] data_byte, [8] done_pin
   input  logic [fsl_pkg::OP_W-1:0]   req_tuser,  // [1:0] operation
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [7:0]                 rsp_tdata,  // [0] mosi, [1] reset_level,
                                                  // [2] select_level, [5:3] phase_code
   input  logic [1:0]                 rsp_tuser,  // [0] clock_pulse, [1] rejected
   input  logic                       rsp_tlast,
   input  logic                       csr_we,
   input  logic [fsl_pkg::IDX_W-1:0]  csr_index,
   input  logic [fsl_pkg::TICK_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         outstanding
);
   import fsl_pkg::*;

   // one serial clock or status result as it should leave the block
   typedef struct packed {
      logic               mosi;
      logic               pulse;
      logic               reset_level;
      logic               select_level;
      logic [PHASE_W-1:0] phase_code;
      logic               rejected;
      logic               last;
   } pin_result_type;

   pin_result_type pin_results_due[$];
   pin_result_type seen;
   pin_result_type wanted;

   // shadow copy of the loader state and its registers
   logic [PHASE_W-1:0]           phase;
   logic [COUNTER_WIDTH_DEF-1:0] delay_count;
   logic                         reset_line;
   logic                         select_line;
   logic [TICK_W-1:0]            hold_ticks;
   logic [TICK_W-1:0]            boot_ticks;
   logic [DUMMY_W-1:0]           dummy_count;

   task automatic add_result(input logic bit_value, input logic pulse, input logic rej);
      pin_result_type r;
      r.mosi         = bit_value;
      r.pulse        = pulse;
      r.reset_level  = reset_line;
      r.select_level = select_line;
      r.phase_code   = phase;
      r.rejected     = rej;
      r.last         = 1'b0;
      pin_results_due.push_back(r);
   endtask

   // a clock pulse for each bit of the byte, msb first
   task automatic add_serial_byte(input logic [BYTE_W-1:0] value);
      for (int b = BYTE_W - 1; b >= 0; b--)
         add_result(value[b], 1'b1, 1'b0);
   endtask

   // one tick of the reset hold or boot wait count
   task automatic count_delay(input logic [TICK_W-1:0] limit,
                              input logic [PHASE_W-1:0] next_phase);
      logic [COUNTER_WIDTH_DEF-1:0] bumped;
      bumped = delay_count + 1'b1;
      if (bumped >= limit || bumped == '1) begin
         delay_count = '0;
         phase = next_phase;
         if (next_phase == PH_BOOT)
            reset_line = 1'b1;
      end else begin
         delay_count = bumped;
      end
   endtask

   task automatic predict_pins(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                               input logic done);
      pin_result_type tail;
      case (op)
         OP_START: begin
            if (phase == PH_IDLE || phase == PH_CONF || phase == PH_FAIL) begin
               reset_line  = 1'b0;
               select_line = 1'b0;
               delay_count = '0;
               phase       = PH_HOLD;
               add_result(1'b0, 1'b0, 1'b0);
            end else begin
               add_result(1'b0, 1'b0, 1'b1);
            end
         end
         OP_TICK: begin
            if (phase == PH_HOLD)
               count_delay(hold_ticks, PH_BOOT);
            else if (phase == PH_BOOT)
               count_delay(boot_ticks, PH_READY);
            add_result(1'b0, 1'b0, 1'b0);
         end
         OP_BYTE: begin
            if (phase == PH_READY)
               add_serial_byte(data);
            else
               add_result(1'b0, 1'b0, 1'b1);
         end
         OP_FINISH: begin
            if (phase != PH_READY) begin
               add_result(1'b0, 1'b0, 1'b1);
            end else if (!done) begin
               phase = PH_FAIL;
               add_result(1'b0, 1'b0, 1'b0);
            end else begin
               phase = PH_CONF;
               for (int n = 0; n < dummy_count; n++)
                  add_serial_byte(FILL_BYTE);
               if (dummy_count == 0)
                  add_result(1'b0, 1'b0, 1'b0);
            end
         end
         default: ;
      endcase
      // flag the final result of this item
      tail = pin_results_due.pop_back();
      tail.last = 1'b1;
      pin_results_due.push_back(tail);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pin_results_due.delete();
         phase       = PH_IDLE;
         delay_count = '0;
         reset_line  = 1'b1;
         select_line = 1'b1;
         hold_ticks  = RESET_HOLD_DEF;
         boot_ticks  = BOOT_WAIT_DEF;
         dummy_count = DUMMY_DEF;
      end else begin
         // compare before predicting: a result never belongs to an item taken in the same cycle
         if (rsp_tvalid && rsp_tready) begin
            seen.mosi         = rsp_tdata[0];
            seen.pulse        = rsp_tuser[0];
            seen.reset_level  = rsp_tdata[1];
            seen.select_level = rsp_tdata[2];
            seen.phase_code   = rsp_tdata[5:3];
            seen.rejected     = rsp_tuser[1];
            seen.last         = rsp_tlast;
            if (pin_results_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result with nothing expected: tdata=%h tuser=%b tlast=%b",
                           $realtime, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               wanted = pin_results_due.pop_front();
               if (seen != wanted) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: expected %b got %b (mosi pulse rst sel phase rej last)",
                              $realtime, wanted, seen);
               end
            end
         end
         // register writes
         if (csr_we) begin
            case (csr_index)
               REG_RESET_HOLD: hold_ticks  = csr_wdata;
               REG_BOOT_WAIT:  boot_ticks  = csr_wdata;
               REG_DUMMY:      dummy_count = csr_wdata[DUMMY_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_pins(req_tuser, req_tdata[7:0], req_tdata[8]);
      end
      outstanding = pin_results_due.size();
   end

endmodule

@@ verif/fpga_spi_config_loader_core_test.sv @@
`timescale 1ns / 1ps

module fpga_spi_config_loader_core_test;
   import fsl_pkg::*;

   localparam int IDLE_PCT    = 14;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 210;
   // index with no register behind it
   localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [15:0]        req_tdata = '0;  // [7:0] data_byte, [8] done_pin
   logic [OP_W-1:0]    req_tuser = '0;  // [1:0] operation
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;       // [0] mosi, [1] reset_level,
                                        // [2] select_level, [5:3] phase_code
   logic [1:0]         rsp_tuser;       // [0] clock_pulse, [1] rejected
   logic               rsp_tlast;
   logic               csr_we = 1'b0;
   logic [IDX_W-1:0]   csr_index = '0;
   logic [TICK_W-1:0]  csr_wdata = '0;

   int fail_count;
   int outstanding;
   int items_sent = 0;
   int idle_cycles = 0;
   bit steady = 1'b0;

   // what the sequence generator believes the registers hold
   logic [TICK_W-1:0]  hold_cfg = RESET_HOLD_DEF;
   logic [TICK_W-1:0]  boot_cfg = BOOT_WAIT_DEF;
   logic [DUMMY_W-1:0] dummy_cfg = DUMMY_DEF;

   fpga_spi_config_loader_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   config_loader_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int span(input logic [TICK_W-1:0] ticks);
      return (ticks == 0) ? 1 : int'(ticks);
   endfunction

   // offer one item, wait for it to be taken, then maybe leave a gap
   task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                            input logic done);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, done, data};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      gap = 0;
      while (!steady && $urandom_range(99) < IDLE_PCT) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending and wait for every predicted result
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register writes, only called with the block drained
   task automatic load_regs(input logic [TICK_W-1:0] hold, input logic [TICK_W-1:0] boot,
                            input logic [DUMMY_W-1:0] dummy);
      csr_we    <= 1'b1;
      csr_index <= REG_RESET_HOLD;
      csr_wdata <= hold;
      @(posedge clock);
      csr_index <= REG_BOOT_WAIT;
      csr_wdata <= boot;
      @(posedge clock);
      csr_index <= REG_DUMMY;
      csr_wdata <= {13'($urandom), dummy};
      @(posedge clock);
      csr_index <= REG_SPARE;
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_we    <= 1'b0;
      hold_cfg  = hold;
      boot_cfg  = boot;
      dummy_cfg = dummy;
   endtask

   // occasional stray item of any kind
   task automatic maybe_noise();
      if ($urandom_range(99) < 12)
         send_item(OP_W'($urandom_range(3)), BYTE_W'($urandom), 1'($urandom));
   endtask

   // start, ticks for both waits (now and then fewer), a few bytes, finish
   task automatic play_sequence();
      int ticks;
      int n_bytes;
      ticks = span(hold_cfg) + span(boot_cfg);
      if ($urandom_range(9) == 0)
         ticks = $urandom_range(ticks);
      send_item(OP_START, BYTE_W'($urandom), 1'($urandom));
      for (int i = 0; i < ticks; i++) begin
         maybe_noise();
         send_item(OP_TICK, BYTE_W'($urandom), 1'($urandom));
      end
      n_bytes = $urandom_range(1, 6);
      for (int i = 0; i < n_bytes; i++) begin
         maybe_noise();
         send_item(OP_BYTE, BYTE_W'($urandom), 1'($urandom));
      end
      maybe_noise();
      send_item(OP_FINISH, BYTE_W'($urandom), $urandom_range(9) != 0);
   endtask

   initial begin
      int seq_index;
      int stop_at;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: mostly wrong-phase items at default settings
      send_item(OP_BYTE, 8'h00, 1'b0);
      send_item(OP_FINISH, 8'hFF, 1'b1);
      send_item(OP_TICK, 8'h00, 1'b0);
      send_item(OP_START, 8'h00, 1'b0);
      send_item(OP_START, 8'hFF, 1'b1);
      send_item(OP_BYTE, 8'hFF, 1'b1);
      send_item(OP_TICK, 8'h00, 1'b0);
      settle();
      // zero hold acts as one tick, then bytes, a one-byte dummy tail and a failed finish
      load_regs(16'd0, 16'd2, 3'd1);
      send_item(OP_TICK, 8'h00, 1'b0);
      send_item(OP_START, 8'h00, 1'b0);
      send_item(OP_FINISH, 8'h00, 1'b1);
      send_item(OP_TICK, 8'h00, 1'b0);
      send_item(OP_TICK, 8'h00, 1'b0);
      send_item(OP_TICK, 8'h00, 1'b0);
      send_item(OP_START, 8'h00, 1'b0);
      send_item(OP_BYTE, 8'h00, 1'b0);
      send_item(OP_BYTE, 8'hFF, 1'b1);
      send_item(OP_BYTE, 8'hA5, 1'b0);
      send_item(OP_FINISH, 8'h5A, 1'b1);
      send_item(OP_FINISH, 8'h00, 1'b1);
      send_item(OP_BYTE, 8'h5A, 1'b0);
      send_item(OP_START, 8'h00, 1'b0);
      send_item(OP_TICK, 8'h00, 1'b0);
      send_item(OP_TICK, 8'h00, 1'b0);
      send_item(OP_TICK, 8'h00, 1'b0);
      send_item(OP_FINISH, 8'hFF, 1'b0);
      settle();

      // random sequences, reconfigured every few, one stretch with no idling
      load_regs(16'd1, 16'd0, 3'd0);
      seq_index = 0;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         steady = (seq_index >= 8 && seq_index < 12);
         play_sequence();
         seq_index++;
         if (seq_index % 4 == 0) begin
            settle();
            load_regs(TICK_W'($urandom_range(4)), TICK_W'($urandom_range(5)),
                      DUMMY_W'($urandom_range(7)));
         end
      end
      settle();

      // full dummy tail back to back
      load_regs(16'd3, 16'd2, 3'd7);
      steady = 1'b1;
      send_item(OP_START, 8'h00, 1'b0);
      for (int i = 0; i < 5; i++)
         send_item(OP_TICK, BYTE_W'($urandom), 1'($urandom));
      send_item(OP_BYTE, BYTE_W'($urandom), 1'b0);
      send_item(OP_BYTE, BYTE_W'($urandom), 1'b0);
      send_item(OP_FINISH, 8'h00, 1'b1);
      steady = 1'b0;
      settle();
      repeat (8) @(posedge clock);

      if (fail_count == 0 && outstanding == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
